// ----- rtl/core/slcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants of the four-digit segment display renderer:
// digit glyphs, the segment-to-display-bit map and the image layout.
// ----------------------------------------------------------------------------
package slcd_pkg;

  // largest value that fits on four digits
  localparam logic [13:0] MaxDisplay = 14'd9999;

  // reciprocal constants for the constant divides
  localparam logic [12:0] RecipHundred = 13'd5243;  // 2^19 / 100, rounded up
  localparam logic [6:0]  RecipTen     = 7'd103;    // 2^10 / 10, rounded up

  // only addresses 1..10 ever carry a lit bit
  localparam int unsigned ImgDepth = 11;
  localparam int unsigned ImgAddrW = 4;

  // fixed symbol positions
  localparam logic [ImgAddrW-1:0] ColonAddr = 4'd8;
  localparam logic [1:0]          ColonCom  = 2'd3;
  localparam logic [ImgAddrW-1:0] PmAddr    = 4'd3;
  localparam logic [1:0]          PmCom     = 2'd3;

  typedef logic [ImgDepth-1:0][3:0] image_t;

  // one segment's display bit
  typedef struct packed {
    logic                vld;
    logic [ImgAddrW-1:0] addr;
    logic [1:0]          com;
  } seg_bit_t;

  // decoded item travelling down the pipeline
  typedef struct packed {
    logic            vld;
    logic            colon;
    logic            pm;
    logic [3:0][3:0] digit;  // digit 0 is the units
  } digits_t;

  localparam seg_bit_t SegNone = '0;

  // segments a..g for units, tens, hundreds, thousands
  localparam seg_bit_t SegMap [4][7] = '{
    '{ '{1'b1, 4'd10, 2'd3}, '{1'b1, 4'd10, 2'd2}, '{1'b1, 4'd10, 2'd1},
       '{1'b1, 4'd9,  2'd1}, '{1'b1, 4'd8,  2'd1}, '{1'b1, 4'd9,  2'd3},
       '{1'b1, 4'd9,  2'd2} },
    '{ '{1'b1, 4'd8,  2'd2}, '{1'b1, 4'd7,  2'd3}, '{1'b1, 4'd7,  2'd1},
       '{1'b1, 4'd6,  2'd1}, '{1'b1, 4'd6,  2'd2}, '{1'b1, 4'd6,  2'd3},
       '{1'b1, 4'd7,  2'd2} },
    '{ '{1'b1, 4'd4,  2'd3}, '{1'b1, 4'd5,  2'd2}, '{1'b1, 4'd5,  2'd1},
       '{1'b1, 4'd4,  2'd1}, '{1'b1, 4'd3,  2'd1}, '{1'b1, 4'd3,  2'd2},
       '{1'b1, 4'd4,  2'd2} },
    '{ SegNone,              '{1'b1, 4'd2,  2'd2}, '{1'b1, 4'd2,  2'd1},
       SegNone,              SegNone,              SegNone,
       '{1'b1, 4'd1,  2'd2} }
  };

  // seven-segment glyph, bit 0 is segment a
  function automatic logic [6:0] glyph_f(input logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'd0:    pat = 7'b0111111;
      4'd1:    pat = 7'b0000110;
      4'd2:    pat = 7'b1011011;
      4'd3:    pat = 7'b1001111;
      4'd4:    pat = 7'b1100110;
      4'd5:    pat = 7'b1101101;
      4'd6:    pat = 7'b1111101;
      4'd7:    pat = 7'b0000111;
      4'd8:    pat = 7'b1111111;
      4'd9:    pat = 7'b1101111;
      default: pat = 7'b0000000;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/core/slcd_split.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_split
// Input register and three stages that clamp the number and split it into
// four decimal digits with reciprocal multiplies.
// ----------------------------------------------------------------------------
module slcd_split
  import slcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        load_i,
  input  logic [15:0] number_i,
  input  logic        colon_i,
  input  logic        pm_i,
  output digits_t     digits_o
);

  // stage valids
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;

  // payload per stage
  logic [15:0] s1_num_q;
  logic [13:0] s2_val_q;
  logic [6:0]  s2_hund_q, s3_hund_q, s3_low_q;
  logic [1:0]  s1_flg_q, s2_flg_q, s3_flg_q, s4_flg_q;
  logic [3:0][3:0] s4_dig_q;

  logic [13:0] val_d;
  logic [26:0] hund_prod;
  logic [6:0]  hund_d;
  logic [13:0] hund_x100;
  logic [6:0]  low_d;
  logic [13:0] hi_prod, lo_prod;
  logic [3:0]  hi_tens, lo_tens;
  logic [6:0]  hi_ten10, lo_ten10;
  logic [3:0][3:0] dig_d;

  // clamp and divide by one hundred
  always_comb begin
    val_d     = (s1_num_q > 16'(MaxDisplay)) ? MaxDisplay : s1_num_q[13:0];
    hund_prod = 27'(val_d) * 27'(RecipHundred);
    hund_d    = hund_prod[25:19];
  end

  // remainder below one hundred
  always_comb begin
    hund_x100 = {1'b0, s2_hund_q, 6'b0} + {2'b0, s2_hund_q, 5'b0} + {5'b0, s2_hund_q, 2'b0};
    low_d     = 7'(s2_val_q - hund_x100);
  end

  // two digits from each half
  always_comb begin
    hi_prod  = 14'(s3_hund_q) * 14'(RecipTen);
    lo_prod  = 14'(s3_low_q) * 14'(RecipTen);
    hi_tens  = hi_prod[13:10];
    lo_tens  = lo_prod[13:10];
    hi_ten10 = {hi_tens, 3'b0} + {2'b0, hi_tens, 1'b0};
    lo_ten10 = {lo_tens, 3'b0} + {2'b0, lo_tens, 1'b0};
    dig_d[3] = hi_tens;
    dig_d[2] = 4'(s3_hund_q - hi_ten10);
    dig_d[1] = lo_tens;
    dig_d[0] = 4'(s3_low_q - lo_ten10);
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= load_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // payload chain
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_num_q  <= number_i;
      s1_flg_q  <= {colon_i, pm_i};
      s2_val_q  <= val_d;
      s2_hund_q <= hund_d;
      s2_flg_q  <= s1_flg_q;
      s3_hund_q <= s2_hund_q;
      s3_low_q  <= low_d;
      s3_flg_q  <= s2_flg_q;
      s4_dig_q  <= dig_d;
      s4_flg_q  <= s3_flg_q;
    end
  end

  assign digits_o.vld   = s4_vld_q;
  assign digits_o.colon = s4_flg_q[1];
  assign digits_o.pm    = s4_flg_q[0];
  assign digits_o.digit = s4_dig_q;

endmodule

// ----- rtl/core/slcd_image.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_image
// Blanks leading zeros, maps lit segments and symbols onto the nibble image
// and holds the finished image until the frame emitter takes it.
// ----------------------------------------------------------------------------
module slcd_image
  import slcd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  digits_t digits_i,
  input  logic    pop_i,
  output logic    adv_o,
  output logic    pend_vld_o,
  output image_t  image_o
);

  logic       pend_vld_q;
  image_t     image_q;
  image_t     image_d;
  logic [3:0] shown;
  logic [3:0][6:0] pats;
  seg_bit_t   ent;

  // whole pipeline moves when the holding slot is free or being emptied
  assign adv_o = !pend_vld_q || pop_i;

  // leading zero blanking
  always_comb begin
    shown[0] = 1'b1;
    shown[3] = digits_i.digit[3] != 4'd0;
    shown[2] = shown[3] || (digits_i.digit[2] != 4'd0);
    shown[1] = shown[2] || (digits_i.digit[1] != 4'd0);
  end

  // segment map and symbols
  always_comb begin
    image_d = '0;
    ent     = SegNone;
    for (int d = 0; d < 4; d++) begin
      pats[d] = glyph_f(digits_i.digit[d]);
      for (int s = 0; s < 7; s++) begin
        ent = SegMap[d][s];
        if (shown[d] && pats[d][s] && ent.vld) begin
          image_d[ent.addr][ent.com] = 1'b1;
        end
      end
    end
    if (digits_i.colon) begin
      image_d[ColonAddr][ColonCom] = 1'b1;
    end
    if (digits_i.pm) begin
      image_d[PmAddr][PmCom] = 1'b1;
    end
  end

  // holding slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
    end else if (adv_o) begin
      pend_vld_q <= digits_i.vld;
    end
  end

  // holding slot image
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      image_q <= image_d;
    end
  end

  assign pend_vld_o = pend_vld_q;
  assign image_o    = image_q;

endmodule

// ----- rtl/core/slcd_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_emit
// Frame emitter: copies a finished image and writes it out one nibble per
// cycle through a registered output, address 0 up to the last address.
// ----------------------------------------------------------------------------
module slcd_emit
  import slcd_pkg::*;
#(
  parameter int unsigned NUM_ADDRESSES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pend_vld_i,
  input  image_t     image_i,
  output logic       pop_o,
  output logic       strobe_o,
  output logic [4:0] addr_o,
  output logic [3:0] nibble_o,
  output logic       last_o
);

  localparam int unsigned CntW = $clog2(NUM_ADDRESSES);

  logic            active_q;
  logic [CntW-1:0] cnt_q;
  image_t          image_q;
  logic            strobe_q, last_q;
  logic [4:0]      addr_q;
  logic [3:0]      nibble_q;
  logic            cnt_last;
  logic [6:0]      addr_ext;
  logic [3:0]      nibble_d;

  assign cnt_last = cnt_q == CntW'(NUM_ADDRESSES - 1);
  assign pop_o    = pend_vld_i && (!active_q || cnt_last);

  // nibble for the current address, blank beyond the mapped range
  always_comb begin
    addr_ext = 7'(cnt_q);
    nibble_d = 4'd0;
    if (addr_ext < 7'(ImgDepth)) begin
      nibble_d = image_q[addr_ext[ImgAddrW-1:0]];
    end
  end

  // frame sequencing and output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= active_q;
      last_q   <= active_q && cnt_last;
      if (pop_o) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        if (cnt_last) begin
          active_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // image copy and output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      image_q <= image_i;
    end
    addr_q   <= 5'(cnt_q);
    nibble_q <= nibble_d;
  end

  assign strobe_o = strobe_q;
  assign addr_o   = addr_q;
  assign nibble_o = nibble_q;
  assign last_o   = last_q;

endmodule

// ----- rtl/core/segment_lcd_four_digit_render_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_lcd_four_digit_render_core
// Renders a four-digit number with colon and PM flags into a nibble image
// for a segment display and writes the image out address by address.
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+------------------
//   command  | display_number_i, colon_flag_i, pm_flag_i      | start_i, busy_o
//   writes   | write_address_o, write_nibble_o, last_write_o  | strobe_o
//
// A frame is NUM_ADDRESSES writes, one per cycle; once frames run back to
// back, a new command is taken only when the frame emitter takes the held
// image for its next frame. A command reaches its first write through the
// input register, the split stages, the image slot and the emitter.
// Up to six commands are in flight: four pipeline stages, the image slot and
// the emitter.
// Reset clears all valid and sequencing state; no writes follow reset.
// The receiver cannot stall; busy_o is high only while the image slot waits.
// ----------------------------------------------------------------------------
module segment_lcd_four_digit_render_core
  import slcd_pkg::*;
#(
  parameter int unsigned NUM_ADDRESSES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] display_number_i,
  input  logic        colon_flag_i,
  input  logic        pm_flag_i,
  output logic        strobe_o,
  output logic [4:0]  write_address_o,
  output logic [3:0]  write_nibble_o,
  output logic        last_write_o
);

  logic    adv;
  logic    load;
  logic    pop;
  logic    pend_vld;
  digits_t digits;
  image_t  image;

  // command transfer
  assign busy_o = !adv;
  assign load   = start_i && adv;

  // digit split pipeline
  slcd_split u_split (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .load_i   (load),
    .number_i (display_number_i),
    .colon_i  (colon_flag_i),
    .pm_i     (pm_flag_i),
    .digits_o (digits)
  );

  // image build and holding slot
  slcd_image u_image (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .digits_i   (digits),
    .pop_i      (pop),
    .adv_o      (adv),
    .pend_vld_o (pend_vld),
    .image_o    (image)
  );

  // frame emitter
  slcd_emit #(
    .NUM_ADDRESSES (NUM_ADDRESSES)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pend_vld_i (pend_vld),
    .image_i    (image),
    .pop_o      (pop),
    .strobe_o   (strobe_o),
    .addr_o     (write_address_o),
    .nibble_o   (write_nibble_o),
    .last_o     (last_write_o)
  );

endmodule

// ----- rtl/core/slcd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_checker
// Port-level checks on the write frames of the display renderer, attached
// to the top level by a bind.
// ----------------------------------------------------------------------------
module slcd_checker #(
  parameter int unsigned NUM_ADDRESSES = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       strobe_o,
  input logic [4:0] write_address_o,
  input logic [3:0] write_nibble_o,
  input logic       last_write_o
);

  localparam logic [4:0] LastAddr = 5'(NUM_ADDRESSES - 1);

  // a frame runs without gaps until its last write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_write_o |=> strobe_o)
    else $error("write frame broken before its last write");

  // addresses step by one inside a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_write_o |=> write_address_o == $past(write_address_o) + 5'd1)
    else $error("write address did not step by one");

  // a frame opens at address zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !$past(strobe_o) |-> write_address_o == 5'd0)
    else $error("write frame did not start at address zero");

  // the last write sits at the final address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_write_o |-> write_address_o == LastAddr)
    else $error("last write flagged at the wrong address");

  // addresses above the mapped range stay blank, the last write aside
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (write_address_o > 5'd10) && !last_write_o && (NUM_ADDRESSES <= 32)
      |-> write_nibble_o == 4'd0)
    else $error("nibble lit at an unmapped address");

endmodule

bind segment_lcd_four_digit_render_core slcd_checker #(
  .NUM_ADDRESSES (NUM_ADDRESSES)
) u_slcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .strobe_o        (strobe_o),
  .write_address_o (write_address_o),
  .write_nibble_o  (write_nibble_o),
  .last_write_o    (last_write_o)
);
